// ----- rtl/dtsf_pkg.sv -----
// Package with the shared types, constants and tables of the decimal to single float converter.
`default_nettype none
package dtsf_pkg;

    localparam int MAX_FRACTION_DIGITS = 9;
    localparam int MANTISSA_BITS       = 23;
    localparam int EXP_BIAS            = 127;
    localparam int EXP_BITS            = 8;
    localparam int INT_BITS            = 31;
    localparam int DIGIT_BITS          = 30;
    localparam int COUNT_BITS          = 4;
    localparam int FLOAT_BITS          = 32;
    localparam int S_TDATA_BITS        = 72;

    localparam logic [EXP_BITS-1:0]   EXP_START = EXP_BITS'(EXP_BIAS + MANTISSA_BITS);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = COUNT_BITS'(MAX_FRACTION_DIGITS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_NORM,
        ST_DONE
    } dtsf_state_t;

    typedef struct packed {
        logic                  valid;
        logic [FLOAT_BITS-1:0] bits;
    } dtsf_result_t;

    function automatic logic [DIGIT_BITS-1:0] pow_ten(input logic [COUNT_BITS-1:0] count);
        logic [DIGIT_BITS-1:0] value;
        case (count)
            4'd0:    value = DIGIT_BITS'(1);
            4'd1:    value = DIGIT_BITS'(10);
            4'd2:    value = DIGIT_BITS'(100);
            4'd3:    value = DIGIT_BITS'(1000);
            4'd4:    value = DIGIT_BITS'(10000);
            4'd5:    value = DIGIT_BITS'(100000);
            4'd6:    value = DIGIT_BITS'(1000000);
            4'd7:    value = DIGIT_BITS'(10000000);
            4'd8:    value = DIGIT_BITS'(100000000);
            default: value = DIGIT_BITS'(1000000000);
        endcase
        return value;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/decimal_to_single_float.sv -----
// Top level of the decimal to IEEE 754 single-precision converter.
//
// The slave stream carries one decimal number per transaction and the master
// stream returns its single-precision bit pattern, truncated toward zero.
// One transaction is taken at a time: s_tready is high only while the
// converter is idle. On acceptance the digit count is saturated, a
// preparation state then saturates the digits, and the normalizer runs one
// step per cycle, either a right shift of a large integer part or one
// doubling of the fraction remainder that appends one binary digit, until
// the leading one sits at mantissa bit 23 or the number is zero. The
// sequencer returns to idle in the same cycle in which the result moves to
// the output register, and only then is the next transaction accepted. A
// finished result sits in an output register; while the receiver holds
// m_tready low the core waits with its next result and takes no new
// transaction. Reset empties the output register and returns the sequencer
// to idle.
`default_nettype none
module decimal_to_single_float (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // negative [0], integer_value [31:1], fraction_digits [61:32],
    // fraction_digit_count [65:62], zero padding [71:66]
    input  wire logic [71:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // float_bits [31:0]
    output logic [31:0]      m_tdata
);
    import dtsf_pkg::*;

    logic                     core_idle;
    logic                     core_start;
    logic                     core_ready;
    dtsf_result_t             core_result;
    logic                     out_valid_reg, out_valid_next;
    logic [FLOAT_BITS-1:0]    out_data_reg, out_data_next;
    logic [S_TDATA_BITS-67:0] pad_unused;

    assign pad_unused = s_tdata[S_TDATA_BITS-1:66];
    assign s_tready   = core_idle && aresetn;
    assign core_start = s_tvalid && s_tready;
    assign core_ready = !out_valid_reg || m_tready;

    dtsf_core u_core (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .start                (core_start),
        .negative             (s_tdata[0]),
        .integer_value        (s_tdata[31:1]),
        .fraction_digits      (s_tdata[61:32]),
        .fraction_digit_count (s_tdata[65:62]),
        .result_ready         (core_ready),
        .idle                 (core_idle),
        .result               (core_result)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (core_ready) begin
            out_valid_next = core_result.valid;
            if (core_result.valid) begin
                out_data_next = core_result.bits;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
`default_nettype wire

// ----- rtl/dtsf_frac_step.sv -----
// Doubling unit that produces one binary fraction bit per use.
`default_nettype none
module dtsf_frac_step (
    input  wire logic [dtsf_pkg::DIGIT_BITS-1:0] rem_in,
    input  wire logic [dtsf_pkg::DIGIT_BITS-1:0] ceiling,
    output logic      [dtsf_pkg::DIGIT_BITS-1:0] rem_out,
    output logic                                 frac_bit
);
    import dtsf_pkg::*;

    logic [DIGIT_BITS:0] doubled;
    logic [DIGIT_BITS:0] reduced;

    always_comb begin
        doubled  = {rem_in, 1'b0};
        reduced  = doubled - {1'b0, ceiling};
        frac_bit = (doubled >= {1'b0, ceiling});
        rem_out  = frac_bit ? reduced[DIGIT_BITS-1:0] : doubled[DIGIT_BITS-1:0];
    end

endmodule
`default_nettype wire

// ----- rtl/dtsf_core.sv -----
// Sequencer and datapath that normalize the number one bit per cycle.
`default_nettype none
module dtsf_core (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 start,
    input  wire logic                                 negative,
    input  wire logic [dtsf_pkg::INT_BITS-1:0]        integer_value,
    input  wire logic [dtsf_pkg::DIGIT_BITS-1:0]      fraction_digits,
    input  wire logic [dtsf_pkg::COUNT_BITS-1:0]      fraction_digit_count,
    input  wire logic                                 result_ready,
    output logic                                      idle,
    output dtsf_pkg::dtsf_result_t                    result
);
    import dtsf_pkg::*;

    dtsf_state_t                 state_reg, state_next;
    logic                        sign_reg, sign_next;
    logic [INT_BITS-1:0]         mant_reg, mant_next;
    logic [DIGIT_BITS-1:0]       rem_reg, rem_next;
    logic [DIGIT_BITS-1:0]       ceil_reg, ceil_next;
    logic [COUNT_BITS-1:0]       count_reg, count_next;
    logic [EXP_BITS-1:0]         exp_reg, exp_next;

    logic [DIGIT_BITS-1:0]       step_rem;
    logic                        step_bit;
    logic [DIGIT_BITS-1:0]       prep_ceil;
    logic                        too_high;
    logic                        is_zero;

    dtsf_frac_step u_frac_step (
        .rem_in   (rem_reg),
        .ceiling  (ceil_reg),
        .rem_out  (step_rem),
        .frac_bit (step_bit)
    );

    assign prep_ceil = pow_ten(count_reg);
    assign too_high  = (mant_reg[INT_BITS-1:MANTISSA_BITS+1] != '0);
    assign is_zero   = (mant_reg == '0) && (rem_reg == '0);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                state_next = ST_NORM;
            end
            ST_NORM: begin
                if (is_zero || (!too_high && mant_reg[MANTISSA_BITS])) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (result_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        sign_next  = sign_reg;
        mant_next  = mant_reg;
        rem_next   = rem_reg;
        ceil_next  = ceil_reg;
        count_next = count_reg;
        exp_next   = exp_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    sign_next  = negative;
                    mant_next  = integer_value;
                    rem_next   = fraction_digits;
                    count_next = (fraction_digit_count > COUNT_MAX) ? COUNT_MAX
                                                                    : fraction_digit_count;
                end
            end
            ST_PREP: begin
                ceil_next = prep_ceil;
                exp_next  = EXP_START;
                if (count_reg == '0) begin
                    rem_next = '0;
                end else if (rem_reg >= prep_ceil) begin
                    rem_next = prep_ceil - DIGIT_BITS'(1);
                end
            end
            ST_NORM: begin
                if (is_zero) begin
                    exp_next = '0;
                end else if (too_high) begin
                    mant_next = {1'b0, mant_reg[INT_BITS-1:1]};
                    exp_next  = exp_reg + EXP_BITS'(1);
                end else if (!mant_reg[MANTISSA_BITS]) begin
                    mant_next = {mant_reg[INT_BITS-2:0], step_bit};
                    rem_next  = step_rem;
                    exp_next  = exp_reg - EXP_BITS'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        idle         = (state_reg == ST_IDLE);
        result.valid = (state_reg == ST_DONE);
        result.bits  = {sign_reg, exp_reg, mant_reg[MANTISSA_BITS-1:0]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        sign_reg  <= sign_next;
        mant_reg  <= mant_next;
        rem_reg   <= rem_next;
        ceil_reg  <= ceil_next;
        count_reg <= count_next;
        exp_reg   <= exp_next;
    end

endmodule
`default_nettype wire

// ----- verif/decimal_to_single_float_tb.sv -----
// Self-checking testbench for the decimal to single-precision float converter stream.
`default_nettype none
module decimal_to_single_float_tb;
    import dtsf_pkg::*;

    localparam int RANDOM_NUMBERS = 950;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 80;
    localparam int MAX_REPORTS    = 10;
    localparam int CASE_COUNT     = 25;

    typedef struct packed {
        logic                  negative;
        logic [INT_BITS-1:0]   integer_value;
        logic [DIGIT_BITS-1:0] fraction_digits;
        logic [COUNT_BITS-1:0] digit_count;
        logic                  known;
        logic [FLOAT_BITS-1:0] float_bits;
    } decimal_case_t;

    logic                    aclk     = 1'b0;
    logic                    aresetn  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata  = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [FLOAT_BITS-1:0]   m_tdata;

    logic [FLOAT_BITS-1:0] expected_floats[$];
    int                    cycle_count    = 0;
    int                    accepted_count = 0;
    int                    error_count    = 0;
    int                    ready_wait     = 0;
    bit                    hold_off       = 1'b0;
    bit                    send_burst     = 1'b0;
    bit                    take_burst     = 1'b0;

    // Rows with a known float_bits are checked against that value directly.
    decimal_case_t directed_cases [CASE_COUNT] = '{
        '{1'b0, 31'd0,          30'd0,          4'd0,  1'b1, 32'h0000_0000},
        '{1'b1, 31'd0,          30'd0,          4'd0,  1'b1, 32'h8000_0000},
        '{1'b0, 31'd1,          30'd0,          4'd0,  1'b1, 32'h3F80_0000},
        '{1'b0, 31'h7FFF_FFFF,  30'd0,          4'd0,  1'b1, 32'h4EFF_FFFF},
        '{1'b1, 31'h7FFF_FFFF,  30'h3FFF_FFFF,  4'd15, 1'b1, 32'hCEFF_FFFF},
        '{1'b0, 31'd0,          30'd5,          4'd1,  1'b1, 32'h3F00_0000},
        '{1'b0, 31'd1,          30'd5,          4'd1,  1'b1, 32'h3FC0_0000},
        '{1'b0, 31'd3,          30'd12345,      4'd0,  1'b1, 32'h4040_0000},
        '{1'b0, 31'd0,          30'h3FFF_FFFF,  4'd0,  1'b1, 32'h0000_0000},
        '{1'b1, 31'd0,          30'd0,          4'd9,  1'b1, 32'h8000_0000},
        '{1'b0, 31'd16777215,   30'd0,          4'd0,  1'b1, 32'h4B7F_FFFF},
        '{1'b0, 31'd0,          30'd25,         4'd2,  1'b1, 32'h3E80_0000},
        '{1'b0, 31'd0,          30'd1,          4'd9,  1'b0, 32'h0},
        '{1'b0, 31'd0,          30'd999999999,  4'd9,  1'b0, 32'h0},
        '{1'b1, 31'd0,          30'd5,          4'd15, 1'b0, 32'h0},
        '{1'b0, 31'd0,          30'd7,          4'd10, 1'b0, 32'h0},
        '{1'b0, 31'd0,          30'h3FFF_FFFF,  4'd1,  1'b0, 32'h0},
        '{1'b0, 31'd0,          30'd1000,       4'd3,  1'b0, 32'h0},
        '{1'b0, 31'd0,          30'd5,          4'd3,  1'b0, 32'h0},
        '{1'b0, 31'd0,          30'd1,          4'd2,  1'b0, 32'h0},
        '{1'b0, 31'd33554431,   30'd999,        4'd3,  1'b0, 32'h0},
        '{1'b0, 31'd12345,      30'd678901234,  4'd9,  1'b0, 32'h0},
        '{1'b1, 31'd1,          30'd1,          4'd9,  1'b0, 32'h0},
        '{1'b0, 31'd8388607,    30'd999999999,  4'd9,  1'b0, 32'h0},
        '{1'b1, 31'd0,          30'd123456789,  4'd9,  1'b0, 32'h0}
    };

    decimal_to_single_float u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [63:0] ten_power(input int digits);
        logic [63:0] value;
        value = 64'd1;
        for (int k = 0; k < digits; k++) begin
            value = value * 64'd10;
        end
        return value;
    endfunction

    // Doubles the remainder and yields the next binary digit of the fraction.
    function automatic logic next_binary_digit(inout logic [63:0] remainder,
                                               input logic [63:0] scale);
        remainder = remainder << 1;
        if (remainder >= scale) begin
            remainder = remainder - scale;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [FLOAT_BITS-1:0] predict_float_bits(
        input logic                  negative,
        input logic [INT_BITS-1:0]   integer_value,
        input logic [DIGIT_BITS-1:0] fraction_digits,
        input logic [COUNT_BITS-1:0] digit_count
    );
        logic [63:0]              remainder;
        logic [63:0]              scale;
        logic [EXP_BITS-1:0]      exponent;
        logic [MANTISSA_BITS-1:0] mantissa;
        logic [FLOAT_BITS-1:0]    shifted;
        int                       digits;
        int                       msb;
        int                       lead;
        digits    = (digit_count > MAX_FRACTION_DIGITS) ? MAX_FRACTION_DIGITS : int'(digit_count);
        scale     = ten_power(digits);
        remainder = (digits == 0) ? 64'd0 : 64'(fraction_digits);
        if (remainder >= scale) begin
            remainder = scale - 64'd1;
        end
        exponent = '0;
        mantissa = '0;
        if (integer_value != '0) begin
            msb = INT_BITS - 1;
            while (msb > 0 && !integer_value[msb]) begin
                msb--;
            end
            exponent = EXP_BITS'(EXP_BIAS + msb);
            if (msb >= MANTISSA_BITS) begin
                mantissa = MANTISSA_BITS'(integer_value >> (msb - MANTISSA_BITS));
            end else begin
                shifted = FLOAT_BITS'(integer_value);
                for (int k = 0; k < MANTISSA_BITS - msb; k++) begin
                    shifted = {shifted[FLOAT_BITS-2:0], next_binary_digit(remainder, scale)};
                end
                mantissa = shifted[MANTISSA_BITS-1:0];
            end
        end else if (remainder != 64'd0) begin
            lead = 0;
            for (int k = 0; k < 64; k++) begin
                lead++;
                if (next_binary_digit(remainder, scale)) begin
                    break;
                end
            end
            exponent = EXP_BITS'(EXP_BIAS - lead);
            for (int k = 0; k < MANTISSA_BITS; k++) begin
                mantissa = {mantissa[MANTISSA_BITS-2:0], next_binary_digit(remainder, scale)};
            end
        end
        return {negative, exponent, mantissa};
    endfunction

    task automatic offer_number(
        input logic                  negative,
        input logic [INT_BITS-1:0]   integer_value,
        input logic [DIGIT_BITS-1:0] fraction_digits,
        input logic [COUNT_BITS-1:0] digit_count,
        input logic                  known,
        input logic [FLOAT_BITS-1:0] known_bits
    );
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, digit_count, fraction_digits, integer_value, negative};
        do @(posedge aclk); while (!s_tready);
        expected_floats = {expected_floats, known ? known_bits
            : predict_float_bits(negative, integer_value, fraction_digits, digit_count)};
        accepted_count++;
        if ($urandom_range(0, 19) == 0) begin
            send_burst = !send_burst;
        end
        @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        if (hold_off || ready_wait > 0) begin
            m_tready <= 1'b0;
            if (!hold_off) begin
                ready_wait--;
            end
        end else begin
            m_tready <= 1'b1;
        end
    end

    // The receiver stops for a long stretch so that the converter backs up into its input.
    initial begin
        wait (accepted_count >= 200);
        @(negedge aclk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off = 1'b0;
    end

    always @(posedge aclk) begin
        logic [FLOAT_BITS-1:0] expected_bits;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_floats.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS) begin
                    $display("UNEXPECTED result transaction float_bits=%h at cycle %0d",
                             m_tdata, cycle_count);
                end
            end else begin
                expected_bits = expected_floats.pop_front();
                if (m_tdata !== expected_bits) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("MISMATCH float_bits expected=%h actual=%h at cycle %0d",
                                 expected_bits, m_tdata, cycle_count);
                    end
                end
            end
            if ($urandom_range(0, 19) == 0) begin
                take_burst = !take_burst;
            end
            ready_wait = take_burst ? 0 : $urandom_range(0, 4);
        end
    end

    initial begin
        logic                  negative;
        logic [INT_BITS-1:0]   integer_value;
        logic [DIGIT_BITS-1:0] fraction_digits;
        logic [COUNT_BITS-1:0] digit_count;
        int                    digits;
        aresetn = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < CASE_COUNT; i++) begin
            offer_number(directed_cases[i].negative, directed_cases[i].integer_value,
                         directed_cases[i].fraction_digits, directed_cases[i].digit_count,
                         directed_cases[i].known, directed_cases[i].float_bits);
        end

        for (int i = 0; i < RANDOM_NUMBERS; i++) begin
            negative = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 4) == 0) begin
                integer_value = '0;
            end else begin
                integer_value = INT_BITS'($urandom) >> $urandom_range(0, INT_BITS - 1);
            end
            if ($urandom_range(0, 9) == 0) begin
                digit_count = COUNT_BITS'($urandom_range(10, 15));
            end else begin
                digit_count = COUNT_BITS'($urandom_range(0, MAX_FRACTION_DIGITS));
            end
            digits = (digit_count > MAX_FRACTION_DIGITS) ? MAX_FRACTION_DIGITS
                                                         : int'(digit_count);
            if ($urandom_range(0, 6) == 0) begin
                fraction_digits = DIGIT_BITS'($urandom);
            end else begin
                fraction_digits = DIGIT_BITS'($urandom_range(0, 32'(ten_power(digits) - 1)));
            end
            offer_number(negative, integer_value, fraction_digits, digit_count, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (expected_floats.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
